### rtl/core/assert_macros.svh
// Assertion helpers for the drive mixer. Each macro expects a clock named clk
// and an active-low reset named rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/owdm_pkg.sv
`default_nettype none

package owdm_pkg;

    localparam int ANGLE_W = 9;
    localparam int SPEED_W = 8;
    localparam int ROT_W = 14;
    localparam int DUTY_W = 8;

    // Fraction bits of the cosine used in the wheel sums.
    localparam int COS_FRAC_BITS = 14;
    localparam int COS_W = COS_FRAC_BITS + 1;
    localparam int PROD_W = COS_W + SPEED_W;
    localparam int SUM_W = COS_FRAC_BITS + 11;
    localparam int ROT_SHIFT = COS_FRAC_BITS - 4;
    localparam int QUOT_W = SUM_W - COS_FRAC_BITS;

    // Rescaling of the Q1.14 table to Q1.COS_FRAC_BITS, round half up.
    localparam int COS_UP = (COS_FRAC_BITS >= 14) ? COS_FRAC_BITS - 14 : 0;
    localparam int COS_DOWN = (COS_FRAC_BITS >= 14) ? 0 : 14 - COS_FRAC_BITS;
    localparam int COS_HALF = (2 ** COS_DOWN) / 2;

    localparam int IDX_W = 7;
    localparam logic [ANGLE_W:0] ANG_QUARTER = 10'd90;
    localparam logic [ANGLE_W:0] ANG_HALF = 10'd180;
    localparam logic [ANGLE_W:0] ANG_THREE_Q = 10'd270;
    localparam logic [ANGLE_W:0] ANG_FULL = 10'd360;
    localparam logic [ANGLE_W:0] ANG_TWO_FULL = 10'd720;

    localparam logic [QUOT_W-1:0] DUTY_MAX = QUOT_W'(255);

    // Configuration register index.
    localparam logic REG_BASE_ANGLE = 1'b0;
    localparam logic [ANGLE_W-1:0] BASE_ANGLE_RST = 9'd315;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } owdm_stage_t;

    // round(cos(d) * 16384) for d = 0..90 degrees.
    localparam logic [14:0] COS_Q14 [0:90] = '{
        15'd16384, 15'd16382, 15'd16374, 15'd16362, 15'd16344, 15'd16322, 15'd16294,
        15'd16262, 15'd16225, 15'd16182, 15'd16135, 15'd16083, 15'd16026, 15'd15964,
        15'd15897, 15'd15826, 15'd15749, 15'd15668, 15'd15582, 15'd15491, 15'd15396,
        15'd15296, 15'd15191, 15'd15082, 15'd14968, 15'd14849, 15'd14726, 15'd14598,
        15'd14466, 15'd14330, 15'd14189, 15'd14044, 15'd13894, 15'd13741, 15'd13583,
        15'd13421, 15'd13255, 15'd13085, 15'd12911, 15'd12733, 15'd12551, 15'd12365,
        15'd12176, 15'd11982, 15'd11786, 15'd11585, 15'd11381, 15'd11174, 15'd10963,
        15'd10749, 15'd10531, 15'd10311, 15'd10087, 15'd9860,  15'd9630,  15'd9397,
        15'd9162,  15'd8923,  15'd8682,  15'd8438,  15'd8192,  15'd7943,  15'd7692,
        15'd7438,  15'd7182,  15'd6924,  15'd6664,  15'd6402,  15'd6138,  15'd5872,
        15'd5604,  15'd5334,  15'd5063,  15'd4790,  15'd4516,  15'd4240,  15'd3964,
        15'd3686,  15'd3406,  15'd3126,  15'd2845,  15'd2563,  15'd2280,  15'd1997,
        15'd1713,  15'd1428,  15'd1143,  15'd857,   15'd572,   15'd286,   15'd0
    };

    function automatic logic [COS_W-1:0] cos_scaled(input logic [IDX_W-1:0] idx);
        logic [31:0] v;
        v = 32'(COS_Q14[idx]) << COS_UP;
        v = (v + 32'(COS_HALF)) >> COS_DOWN;
        return COS_W'(v);
    endfunction

endpackage

`default_nettype wire

### rtl/core/owdm_pipe_ctrl.sv
`default_nettype none

module owdm_pipe_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    input  wire logic                 out_stall,
    output owdm_pkg::owdm_stage_t     adv,
    output owdm_pkg::owdm_stage_t     vld,
    output logic                      in_stall
);
    import owdm_pkg::*;

    owdm_stage_t vld_reg;
    owdm_stage_t vld_next;
    owdm_stage_t rdy;

    // A stage may load when it is empty or its occupant moves on.
    always_comb
    begin
        rdy.s4 = !vld_reg.s4 || !out_stall;
        rdy.s3 = !vld_reg.s3 || rdy.s4;
        rdy.s2 = !vld_reg.s2 || rdy.s3;
        rdy.s1 = !vld_reg.s1 || rdy.s2;

        vld_next.s1 = rdy.s1 ? in_valid    : vld_reg.s1;
        vld_next.s2 = rdy.s2 ? vld_reg.s1  : vld_reg.s2;
        vld_next.s3 = rdy.s3 ? vld_reg.s2  : vld_reg.s3;
        vld_next.s4 = rdy.s4 ? vld_reg.s3  : vld_reg.s4;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign adv      = rdy;
    assign vld      = vld_reg;
    assign in_stall = !rdy.s1;

endmodule

`default_nettype wire

### rtl/core/owdm_angle.sv
`default_nettype none

module owdm_angle (
    input  wire logic                              clk,
    input  wire logic                              load,
    input  wire logic [owdm_pkg::ANGLE_W-1:0]      base_angle,
    input  wire logic [owdm_pkg::ANGLE_W-1:0]      heading_deg,
    input  wire logic [owdm_pkg::SPEED_W-1:0]      speed,
    input  wire logic signed [owdm_pkg::ROT_W-1:0] rotation,
    output logic [owdm_pkg::ANGLE_W-1:0]           angle,
    output logic [owdm_pkg::SPEED_W-1:0]           speed_q,
    output logic signed [owdm_pkg::ROT_W-1:0]      rotation_q
);
    import owdm_pkg::*;

    logic [ANGLE_W:0]          sum_raw;
    logic [ANGLE_W:0]          sum_a;
    logic [ANGLE_W:0]          sum_b;
    logic [ANGLE_W-1:0]        angle_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic signed [ROT_W-1:0]   rot_reg;

    // Both operands are below 512, so two conditional subtractions bring the
    // sum into the range 0..359.
    always_comb
    begin
        sum_raw = (ANGLE_W + 1)'(base_angle) + (ANGLE_W + 1)'(heading_deg);
        sum_a   = (sum_raw >= ANG_TWO_FULL) ? sum_raw - ANG_TWO_FULL : sum_raw;
        sum_b   = (sum_a >= ANG_FULL) ? sum_a - ANG_FULL : sum_a;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            angle_reg <= sum_b[ANGLE_W-1:0];
            speed_reg <= speed;
            rot_reg   <= rotation;
        end
    end

    assign angle      = angle_reg;
    assign speed_q    = speed_reg;
    assign rotation_q = rot_reg;

endmodule

`default_nettype wire

### rtl/core/owdm_lane.sv
`default_nettype none

module owdm_lane (
    input  wire logic                              clk,
    input  wire owdm_pkg::owdm_stage_t             adv,
    input  wire logic [1:0]                        wheel,
    input  wire logic [owdm_pkg::ANGLE_W-1:0]      angle,
    input  wire logic [owdm_pkg::SPEED_W-1:0]      speed,
    input  wire logic signed [owdm_pkg::ROT_W-1:0] rotation,
    output logic [owdm_pkg::DUTY_W-1:0]            duty,
    output logic                                   fwd
);
    import owdm_pkg::*;

    logic [ANGLE_W:0]          wheel_off;
    logic [ANGLE_W:0]          ang_raw;
    logic [ANGLE_W:0]          ang;
    logic [ANGLE_W:0]          idx_wide;
    logic                      neg;

    logic [COS_W-1:0]          cos_reg;
    logic                      neg_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic signed [ROT_W-1:0]   rot_reg;

    logic [PROD_W-1:0]         prod;
    logic signed [SUM_W-1:0]   term;
    logic signed [SUM_W-1:0]   rot_q;
    logic signed [SUM_W-1:0]   sum_reg;

    logic [SUM_W-1:0]          mag;
    logic [QUOT_W-1:0]         quot;
    logic [DUTY_W-1:0]         duty_reg;
    logic                      fwd_reg;

    // Stage two: wheel angle, quadrant fold and table read.
    always_comb
    begin
        wheel_off = (ANGLE_W + 1)'(wheel) * ANG_QUARTER;
        ang_raw   = (ANGLE_W + 1)'(angle) + wheel_off;
        ang       = (ang_raw >= ANG_FULL) ? ang_raw - ANG_FULL : ang_raw;
        if (ang <= ANG_QUARTER)
        begin
            idx_wide = ang;
            neg      = 1'b0;
        end
        else if (ang <= ANG_HALF)
        begin
            idx_wide = ANG_HALF - ang;
            neg      = 1'b1;
        end
        else if (ang <= ANG_THREE_Q)
        begin
            idx_wide = ang - ANG_HALF;
            neg      = 1'b1;
        end
        else
        begin
            idx_wide = ANG_FULL - ang;
            neg      = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv.s2)
        begin
            cos_reg   <= cos_scaled(idx_wide[IDX_W-1:0]);
            neg_reg   <= neg;
            speed_reg <= speed;
            rot_reg   <= rotation;
        end
    end

    // Stage three: cosine times speed plus the scaled rotation term.
    always_comb
    begin
        prod  = PROD_W'(cos_reg) * PROD_W'(speed_reg);
        term  = signed'(SUM_W'(prod));
        if (neg_reg)
        begin
            term = -term;
        end
        rot_q = SUM_W'(rot_reg) <<< ROT_SHIFT;
    end

    always_ff @(posedge clk)
    begin
        if (adv.s3)
        begin
            sum_reg <= term + rot_q;
        end
    end

    // Stage four: magnitude truncated toward zero, saturated to the duty range.
    always_comb
    begin
        mag  = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
        quot = mag[SUM_W-1:COS_FRAC_BITS];
    end

    always_ff @(posedge clk)
    begin
        if (adv.s4)
        begin
            duty_reg <= (quot > DUTY_MAX) ? DUTY_MAX[DUTY_W-1:0] : quot[DUTY_W-1:0];
            fwd_reg  <= !sum_reg[SUM_W-1];
        end
    end

    assign duty = duty_reg;
    assign fwd  = fwd_reg;

endmodule

`default_nettype wire

### rtl/core/omni_wheel_drive_mixer.sv
// Four-wheel omni drive mixer.
// An item on the input channel (heading_deg, speed, rotation) is taken at a
// clock edge where in_valid is high and in_stall is low. Each item yields one
// result item with a duty magnitude and a forward flag for each of the four
// wheels, offered on out_valid and taken when out_stall is low.
// The datapath is a four-stage pipeline: angle reduction, wheel angle and
// cosine table read, multiply and add, then magnitude and saturation. One
// item per cycle is sustained while out_stall is low. The multiply-add stage
// sets the clock period.
// When the receiver stalls, the result holds on the outputs and the stages
// behind it keep filling until every stage is occupied; only then does
// in_stall rise. Nothing is dropped or repeated.
// The base_angle register is written over the APB port at byte address 0 and
// the user must change it only while the pipeline is empty; the block itself
// does not enforce this. Reset empties the pipeline and sets base_angle to
// 315 degrees (IMU layout); 45 selects the plain layout.
`default_nettype none

`include "assert_macros.svh"

module omni_wheel_drive_mixer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,

    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [2:0]                        paddr,
    input  wire logic [31:0]                       pwdata,
    output logic [31:0]                            prdata,
    output logic                                   pready,

    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [owdm_pkg::ANGLE_W-1:0]      heading_deg,
    input  wire logic [owdm_pkg::SPEED_W-1:0]      speed,
    input  wire logic signed [owdm_pkg::ROT_W-1:0] rotation,

    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [owdm_pkg::DUTY_W-1:0]            duty_one,
    output logic [owdm_pkg::DUTY_W-1:0]            duty_two,
    output logic [owdm_pkg::DUTY_W-1:0]            duty_three,
    output logic [owdm_pkg::DUTY_W-1:0]            duty_four,
    output logic                                   fwd_one,
    output logic                                   fwd_two,
    output logic                                   fwd_three,
    output logic                                   fwd_four
);
    import owdm_pkg::*;

    logic [ANGLE_W-1:0]        base_reg;
    logic [ANGLE_W-1:0]        base_next;
    logic                      reg_idx;
    logic                      wr_en;

    owdm_stage_t               adv;
    owdm_stage_t               vld;

    logic [ANGLE_W-1:0]        angle_s1;
    logic [SPEED_W-1:0]        speed_s1;
    logic signed [ROT_W-1:0]   rot_s1;

    // Configuration port: pready is always high, one register per 32-bit word.
    assign pready  = 1'b1;
    assign reg_idx = paddr[2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        base_next = base_reg;
        prdata    = '0;
        unique case (reg_idx)
            REG_BASE_ANGLE:
            begin
                prdata = 32'(base_reg);
                if (wr_en)
                begin
                    base_next = pwdata[ANGLE_W-1:0];
                end
            end
            default:
            begin
                prdata = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= BASE_ANGLE_RST;
        end
        else
        begin
            base_reg <= base_next;
        end
    end

    // Valid bits and per-stage load enables.
    owdm_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .adv       (adv),
        .vld       (vld),
        .in_stall  (in_stall)
    );

    assign out_valid = vld.s4;

    // Stage one: the heading plus the base angle, reduced modulo 360. This is
    // shared by all four wheels since they differ only by quarter turns.
    owdm_angle u_angle (
        .clk         (clk),
        .load        (adv.s1),
        .base_angle  (base_reg),
        .heading_deg (heading_deg),
        .speed       (speed),
        .rotation    (rotation),
        .angle       (angle_s1),
        .speed_q     (speed_s1),
        .rotation_q  (rot_s1)
    );

    // One lane per wheel; wheel k is offset by k quarter turns.
    owdm_lane u_lane_one (
        .clk      (clk),
        .adv      (adv),
        .wheel    (2'd0),
        .angle    (angle_s1),
        .speed    (speed_s1),
        .rotation (rot_s1),
        .duty     (duty_one),
        .fwd      (fwd_one)
    );

    owdm_lane u_lane_two (
        .clk      (clk),
        .adv      (adv),
        .wheel    (2'd1),
        .angle    (angle_s1),
        .speed    (speed_s1),
        .rotation (rot_s1),
        .duty     (duty_two),
        .fwd      (fwd_two)
    );

    owdm_lane u_lane_three (
        .clk      (clk),
        .adv      (adv),
        .wheel    (2'd2),
        .angle    (angle_s1),
        .speed    (speed_s1),
        .rotation (rot_s1),
        .duty     (duty_three),
        .fwd      (fwd_three)
    );

    owdm_lane u_lane_four (
        .clk      (clk),
        .adv      (adv),
        .wheel    (2'd3),
        .angle    (angle_s1),
        .speed    (speed_s1),
        .rotation (rot_s1),
        .duty     (duty_four),
        .fwd      (fwd_four)
    );

    // Back pressure reaches the input only once every stage holds an item.
    `ASSERT_SAME(a_stall_full, in_stall, vld.s1 && vld.s2 && vld.s3 && vld.s4, "input stalled with a bubble in the pipeline")
    // The shared reduced angle is always a proper angle.
    `ASSERT_SAME(a_angle_range, vld.s1, angle_s1 < ANG_FULL[ANGLE_W-1:0], "reduced angle out of range")
    // A result held under stall keeps out_valid, duty_one and fwd_four next cycle.
    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(duty_one) && $stable(fwd_four), "stalled result changed")

endmodule

`default_nettype wire
